// ===== rtl/decaying_rate_meter_bank_defines.svh =====
// ----------------------------------------------------------------------------
// decaying_rate_meter_bank_defines
// assertion macros for the meter bank, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef DECAYING_RATE_METER_BANK_DEFINES_SVH
`define DECAYING_RATE_METER_BANK_DEFINES_SVH
`ifndef NO_ASSERTIONS
// property checked on every clock edge outside reset
`define DRM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);
// condition in one cycle implies a consequence in the next
`define DRM_ASSERT_NXT(lbl, cond, nxt_cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt_cond)) \
    else $error(msg);
`else
`define DRM_ASSERT(lbl, prop, msg)
`define DRM_ASSERT_NXT(lbl, cond, nxt_cond, msg)
`endif
`endif

// ===== rtl/drm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drm_pkg
// shared types, constants and arithmetic helpers of the rate meter bank
// ----------------------------------------------------------------------------
package drm_pkg;

  localparam int NUM_METERS       = 64;
  localparam int ADDR_W           = (NUM_METERS > 1) ? $clog2(NUM_METERS) : 1;
  localparam int TICKS_PER_SEC    = 7;
  localparam int USEC_PER_SEC     = 1000000;
  localparam int HISTORY_TICKS    = 166;
  localparam int STEP_W           = 8;
  localparam logic [31:0] RATE_SCALE_LIMIT = 32'h0FFF_FFFF;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_DECAY,
    S_WRITE
  } state_t;

  typedef struct packed {
    logic [63:0] total;
    logic [31:0] rate;
    logic [31:0] last_tick;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic              start;
    logic [31:0]       rate;
    logic [STEP_W-1:0] steps;
  } decay_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] rate;
  } decay_res_t;

  // seconds*7 + (microseconds*7)/1e6, modulo 2^32
  function automatic logic [31:0] tick_of(input logic [31:0] sec, input logic [19:0] usec);
    logic [31:0] s7;
    logic [22:0] u7;
    logic [2:0]  frac;
    s7   = (sec << 3) - sec;
    u7   = ({3'b000, usec} << 3) - {3'b000, usec};
    frac = 3'd0;
    for (int k = 1; k <= TICKS_PER_SEC; k++) begin
      if (u7 >= 23'(k * USEC_PER_SEC)) begin
        frac = frac + 3'd1;
      end
    end
    return s7 + 32'(frac);
  endfunction

  // one decay tick: r - (r+7)/8 with the sum wrapping at 32 bits
  function automatic logic [31:0] decay_step(input logic [31:0] r);
    logic [31:0] sum;
    sum = r + 32'd7;
    return r - (sum >> 3);
  endfunction

  // rate in units per second
  function automatic logic [31:0] scaled_rate(input logic [31:0] r);
    logic [31:0] q;
    logic [31:0] m;
    q = r >> 3;
    m = (r << 3) - r;
    if (r > RATE_SCALE_LIMIT) begin
      return (q << 3) - q;
    end
    return (m + 32'd7) >> 3;
  endfunction

endpackage

// ===== rtl/decaying_rate_meter_bank.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decaying_rate_meter_bank
// bank of traffic meters with a 64-bit total and an exponentially decaying rate
// ----------------------------------------------------------------------------
// usage:
//   an item (meter_select, clear_first, seconds, microseconds, amount) is taken
//   when start is high and busy is low. exactly one result per item comes back
//   on out_rate_per_sec / out_grand_total, marked by a one-cycle out_valid
//   strobe. the receiver cannot stall; results are simply presented once.
//   after accept the item passes S_READ, then S_DECAY, where the decay unit
//   runs the elapsed ticks (cut short when the rate reaches zero), then
//   S_WRITE, which registers the strobe; when more than 166 ticks have
//   passed, S_DECAY is skipped and the rate is simply replaced. items are
//   handled one at a time; busy stays high until the write-back is done and
//   is low again while the strobe is shown, so the next item can be taken then.
//   the decay unit runs one tick per cycle; the meter state lives in one
//   ram, read once and written back once per item.
//   an item naming a meter beyond the bank gives a zero result in the next
//   cycle and changes nothing.
//   after reset the ram is swept to zero, one meter per cycle (all
//   NUM_METERS meters, 64 here), with busy high.
// ----------------------------------------------------------------------------
`include "decaying_rate_meter_bank_defines.svh"

module decaying_rate_meter_bank (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [5:0]  in_meter_select,
  input  logic        in_clear_first,
  input  logic [31:0] in_seconds,
  input  logic [19:0] in_microseconds,
  input  logic [31:0] in_amount,
  output logic        out_valid,
  output logic [31:0] out_rate_per_sec,
  output logic [63:0] out_grand_total
);

  import drm_pkg::*;

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [31:0]       now_r, now_nxt;
  logic [31:0]       amt_r, amt_nxt;
  logic              clr_r, clr_nxt;
  logic [63:0]       total_r, total_nxt;
  logic [31:0]       rate_r, rate_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [31:0]       out_rate_r, out_rate_nxt;
  logic [63:0]       out_total_r, out_total_nxt;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  entry_t            ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  entry_t            ram_rdata;
  entry_t            entry;
  logic [31:0]       diff;
  logic              in_range;

  decay_req_t        dec_req;
  decay_res_t        dec_res;

  drm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_METERS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  drm_decay u_decay (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dec_req),
    .res   (dec_res)
  );

  assign in_range = (32'(in_meter_select) < 32'(NUM_METERS));
  assign entry    = clr_r ? '0 : ram_rdata;
  assign diff     = now_r - entry.last_tick;

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    addr_nxt      = addr_r;
    now_nxt       = now_r;
    amt_nxt       = amt_r;
    clr_nxt       = clr_r;
    total_nxt     = total_r;
    rate_nxt      = rate_r;
    out_valid_nxt = 1'b0;
    out_rate_nxt  = out_rate_r;
    out_total_nxt = out_total_r;
    ram_we        = 1'b0;
    ram_waddr     = addr_r;
    ram_wdata     = '{total: total_r, rate: rate_r, last_tick: now_r};
    ram_re        = 1'b0;
    ram_raddr     = ADDR_W'(in_meter_select);
    dec_req       = '{start: 1'b0, rate: entry.rate, steps: diff[STEP_W-1:0]};

    unique case (state_r)
      S_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        ram_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == ADDR_W'(NUM_METERS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          if (in_range) begin
            ram_re    = 1'b1;
            addr_nxt  = ADDR_W'(in_meter_select);
            now_nxt   = tick_of(in_seconds, in_microseconds);
            amt_nxt   = in_amount;
            clr_nxt   = in_clear_first;
            state_nxt = S_READ;
          end else begin
            out_valid_nxt = 1'b1;
            out_rate_nxt  = '0;
            out_total_nxt = '0;
          end
        end
      end
      S_READ: begin
        total_nxt = entry.total + 64'(amt_r);
        if (diff > 32'(HISTORY_TICKS)) begin
          rate_nxt  = amt_r;
          state_nxt = S_WRITE;
        end else begin
          dec_req.start = 1'b1;
          state_nxt     = S_DECAY;
        end
      end
      S_DECAY: begin
        if (dec_res.done) begin
          rate_nxt  = dec_res.rate + amt_r;
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        ram_we        = 1'b1;
        out_valid_nxt = 1'b1;
        out_rate_nxt  = scaled_rate(rate_r);
        out_total_nxt = total_r;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r      <= addr_nxt;
    now_r       <= now_nxt;
    amt_r       <= amt_nxt;
    clr_r       <= clr_nxt;
    total_r     <= total_nxt;
    rate_r      <= rate_nxt;
    out_rate_r  <= out_rate_nxt;
    out_total_r <= out_total_nxt;
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_rate_per_sec = out_rate_r;
  assign out_grand_total  = out_total_r;

  `DRM_ASSERT_NXT(a_accept_reads, start && !busy && in_range, state_r == S_READ, "item not read")
  `DRM_ASSERT_NXT(a_write_reports, state_r == S_WRITE, out_valid, "write-back without strobe")
  `DRM_ASSERT(a_done_in_decay, !dec_res.done || (state_r == S_DECAY), "decay done out of step")
  `DRM_ASSERT(a_idle_decay_quiet, busy || !dec_res.busy, "decay unit busy while idle")

endmodule

// ===== rtl/drm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drm_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module drm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/drm_decay.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drm_decay
// iterative decay unit, one tick of rate decay per cycle
// ----------------------------------------------------------------------------
module drm_decay (
  input  logic                clk,
  input  logic                rst_n,
  input  drm_pkg::decay_req_t req,
  output drm_pkg::decay_res_t res
);

  import drm_pkg::*;

  logic              busy_r, busy_nxt;
  logic [31:0]       rate_r, rate_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              done;

  assign done = busy_r && ((cnt_r == '0) || (rate_r == '0));

  always_comb begin
    busy_nxt = busy_r;
    rate_nxt = rate_r;
    cnt_nxt  = cnt_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      rate_nxt = req.rate;
      cnt_nxt  = req.steps;
    end else if (done) begin
      busy_nxt = 1'b0;
    end else if (busy_r) begin
      rate_nxt = decay_step(rate_r);
      cnt_nxt  = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rate_r <= rate_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign res.busy = busy_r;
  assign res.done = done;
  assign res.rate = rate_r;

endmodule
